// ===== hdl/dnsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the DNS response A-record parser.
// No dependencies; used by dnsp_parser and the top level.
package dnsp_pkg;

    localparam int MAX_PACKET_BYTES = 512;
    localparam int MAX_NAME_LABELS  = 128;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int GUARD_W          = 8;

    localparam logic [15:0] DEFAULT_TXID = 16'h5A17;
    localparam logic [7:0]  PTR_MASK     = 8'hC0;
    localparam logic [15:0] QR_MASK      = 16'h8000;
    localparam logic [15:0] RCODE_MASK   = 16'h000F;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] A_RDLEN      = 16'd4;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NONE      = 2'd1;
    localparam logic [1:0] ST_FAILED    = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QNAME,
        PH_QFIXED,
        PH_ANAME,
        PH_AFIXED,
        PH_RDATA,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        NAME_MORE,
        NAME_END,
        NAME_BAD
    } name_res_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ipv4_address;
    } result_t;

endpackage

// ===== hdl/dnsp_parser.sv =====
`timescale 1ns / 1ps
// Per-byte parse state and its update; yields the verdict on the last byte.
// Depends on dnsp_pkg.
module dnsp_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [15:0]          expected_txid,
    output dnsp_pkg::result_t    result
);

    logic [dnsp_pkg::POS_W-1:0]   pos_reg, pos_next;
    dnsp_pkg::phase_t             phase_reg, phase_next;
    logic [15:0]                  hword_reg, hword_next;
    logic                         hbad_reg, hbad_next;
    logic [15:0]                  qleft_reg, qleft_next;
    logic [15:0]                  aleft_reg, aleft_next;
    logic [5:0]                   lbl_reg, lbl_next;
    logic [dnsp_pkg::GUARD_W-1:0] guard_reg, guard_next;
    logic                         ptr_reg, ptr_next;
    logic [3:0]                   ridx_reg, ridx_next;
    logic [15:0]                  rtype_reg, rtype_next;
    logic [15:0]                  rdleft_reg, rdleft_next;
    logic                         amatch_reg, amatch_next;
    logic [31:0]                  accum_reg, accum_next;
    logic [1:0]                   verdict_reg, verdict_next;

    dnsp_pkg::name_res_t          name_res;
    logic [5:0]                   n_lbl;
    logic [dnsp_pkg::GUARD_W-1:0] n_guard;
    logic                         n_ptr;
    logic [15:0]                  hword_new;
    logic [15:0]                  aleft_dec;
    logic [15:0]                  rtype_new;
    logic [15:0]                  rdata_new;
    logic [15:0]                  rdleft_dec;
    logic [15:0]                  qleft_dec;
    logic [3:0]                   ridx_inc;
    logic [1:0]                   status;

    // name walker shared by question and answer names
    always_comb
    begin
        name_res = dnsp_pkg::NAME_MORE;
        n_lbl    = lbl_reg;
        n_guard  = guard_reg;
        n_ptr    = ptr_reg;
        if (lbl_reg != 6'd0)
        begin
            n_lbl = lbl_reg - 6'd1;
            if (lbl_reg == 6'd1 && ptr_reg)
                name_res = dnsp_pkg::NAME_END;
        end
        else if (guard_reg >= dnsp_pkg::GUARD_W'(dnsp_pkg::MAX_NAME_LABELS))
        begin
            name_res = dnsp_pkg::NAME_BAD;
        end
        else
        begin
            n_guard = guard_reg + 1'b1;
            if (data_byte == 8'd0)
                name_res = dnsp_pkg::NAME_END;
            else if ((data_byte & dnsp_pkg::PTR_MASK) == dnsp_pkg::PTR_MASK)
            begin
                n_lbl = 6'd1;
                n_ptr = 1'b1;
            end
            else if ((data_byte & dnsp_pkg::PTR_MASK) != 8'd0)
                name_res = dnsp_pkg::NAME_BAD;
            else
                n_lbl = data_byte[5:0];
        end
    end

    assign hword_new  = {hword_reg[7:0], data_byte};
    assign aleft_dec  = aleft_reg - 16'd1;
    assign qleft_dec  = qleft_reg - 16'd1;
    assign rdleft_dec = rdleft_reg - 16'd1;
    assign ridx_inc   = ridx_reg + 4'd1;
    assign rtype_new  = (ridx_reg < 4'd2) ? {rtype_reg[7:0], data_byte} : rtype_reg;
    assign rdata_new  = (ridx_reg >= 4'd8) ? {rdleft_reg[7:0], data_byte} : rdleft_reg;

    // byte update
    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        hword_next   = hword_reg;
        hbad_next    = hbad_reg;
        qleft_next   = qleft_reg;
        aleft_next   = aleft_reg;
        lbl_next     = lbl_reg;
        guard_next   = guard_reg;
        ptr_next     = ptr_reg;
        ridx_next    = ridx_reg;
        rtype_next   = rtype_reg;
        rdleft_next  = rdleft_reg;
        amatch_next  = amatch_reg;
        accum_next   = accum_reg;
        verdict_next = verdict_reg;

        if (pos_reg < dnsp_pkg::POS_W'(dnsp_pkg::MAX_PACKET_BYTES))
        begin
            pos_next = pos_reg + 1'b1;
            case (phase_reg)
                dnsp_pkg::PH_HEADER:
                begin
                    hword_next = hword_new;
                    if (pos_reg == dnsp_pkg::POS_W'(1) && hword_new != expected_txid)
                        hbad_next = 1'b1;
                    if (pos_reg == dnsp_pkg::POS_W'(3)
                        && ((hword_new & dnsp_pkg::QR_MASK) == 16'd0
                        || (hword_new & dnsp_pkg::RCODE_MASK) != 16'd0))
                        hbad_next = 1'b1;
                    if (pos_reg == dnsp_pkg::POS_W'(5))
                        qleft_next = hword_new;
                    if (pos_reg == dnsp_pkg::POS_W'(7))
                    begin
                        aleft_next = hword_new;
                        if (hword_new == 16'd0)
                            hbad_next = 1'b1;
                    end
                    if (pos_reg == dnsp_pkg::POS_W'(11))
                    begin
                        if (hbad_reg)
                        begin
                            verdict_next = dnsp_pkg::ST_FAILED;
                            phase_next   = dnsp_pkg::PH_DONE;
                        end
                        else if (qleft_reg == 16'd0)
                            phase_next = dnsp_pkg::PH_ANAME;
                        else
                            phase_next = dnsp_pkg::PH_QNAME;
                    end
                end
                dnsp_pkg::PH_QNAME:
                begin
                    lbl_next   = n_lbl;
                    guard_next = n_guard;
                    ptr_next   = n_ptr;
                    if (name_res == dnsp_pkg::NAME_BAD)
                    begin
                        verdict_next = dnsp_pkg::ST_MALFORMED;
                        phase_next   = dnsp_pkg::PH_DONE;
                    end
                    else if (name_res == dnsp_pkg::NAME_END)
                    begin
                        lbl_next   = 6'd0;
                        guard_next = '0;
                        ptr_next   = 1'b0;
                        ridx_next  = 4'd0;
                        phase_next = dnsp_pkg::PH_QFIXED;
                    end
                end
                dnsp_pkg::PH_QFIXED:
                begin
                    ridx_next = ridx_inc;
                    if (ridx_inc >= 4'd4)
                    begin
                        qleft_next = qleft_dec;
                        phase_next = (qleft_dec == 16'd0) ? dnsp_pkg::PH_ANAME
                                                          : dnsp_pkg::PH_QNAME;
                    end
                end
                dnsp_pkg::PH_ANAME:
                begin
                    lbl_next   = n_lbl;
                    guard_next = n_guard;
                    ptr_next   = n_ptr;
                    if (name_res == dnsp_pkg::NAME_BAD)
                    begin
                        verdict_next = dnsp_pkg::ST_NONE;
                        phase_next   = dnsp_pkg::PH_DONE;
                    end
                    else if (name_res == dnsp_pkg::NAME_END)
                    begin
                        lbl_next    = 6'd0;
                        guard_next  = '0;
                        ptr_next    = 1'b0;
                        ridx_next   = 4'd0;
                        rtype_next  = 16'd0;
                        rdleft_next = 16'd0;
                        phase_next  = dnsp_pkg::PH_AFIXED;
                    end
                end
                dnsp_pkg::PH_AFIXED:
                begin
                    rtype_next  = rtype_new;
                    rdleft_next = rdata_new;
                    ridx_next   = ridx_inc;
                    if (ridx_inc >= 4'd10)
                    begin
                        amatch_next = (rtype_new == dnsp_pkg::TYPE_A)
                                      && (rdata_new == dnsp_pkg::A_RDLEN);
                        accum_next  = 32'd0;
                        if (rdata_new == 16'd0)
                        begin
                            aleft_next = aleft_dec;
                            if (aleft_dec == 16'd0)
                            begin
                                verdict_next = dnsp_pkg::ST_NONE;
                                phase_next   = dnsp_pkg::PH_DONE;
                            end
                            else
                                phase_next = dnsp_pkg::PH_ANAME;
                        end
                        else
                            phase_next = dnsp_pkg::PH_RDATA;
                    end
                end
                dnsp_pkg::PH_RDATA:
                begin
                    if (amatch_reg)
                        accum_next = {accum_reg[23:0], data_byte};
                    rdleft_next = rdleft_dec;
                    if (rdleft_dec == 16'd0)
                    begin
                        if (amatch_reg)
                        begin
                            verdict_next = dnsp_pkg::ST_FOUND;
                            phase_next   = dnsp_pkg::PH_DONE;
                        end
                        else
                        begin
                            aleft_next = aleft_dec;
                            if (aleft_dec == 16'd0)
                            begin
                                verdict_next = dnsp_pkg::ST_NONE;
                                phase_next   = dnsp_pkg::PH_DONE;
                            end
                            else
                                phase_next = dnsp_pkg::PH_ANAME;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // verdict from the state after this byte
    always_comb
    begin
        case (phase_next)
            dnsp_pkg::PH_HEADER: status = dnsp_pkg::ST_FAILED;
            dnsp_pkg::PH_QNAME:  status = dnsp_pkg::ST_MALFORMED;
            dnsp_pkg::PH_QFIXED: status = dnsp_pkg::ST_MALFORMED;
            dnsp_pkg::PH_DONE:   status = verdict_next;
            default:             status = dnsp_pkg::ST_NONE;
        endcase
        result.status       = status;
        result.ipv4_address = (status == dnsp_pkg::ST_FOUND) ? accum_next : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= dnsp_pkg::PH_HEADER;
            hword_reg   <= '0;
            hbad_reg    <= 1'b0;
            qleft_reg   <= '0;
            aleft_reg   <= '0;
            lbl_reg     <= '0;
            guard_reg   <= '0;
            ptr_reg     <= 1'b0;
            ridx_reg    <= '0;
            rtype_reg   <= '0;
            rdleft_reg  <= '0;
            amatch_reg  <= 1'b0;
            accum_reg   <= '0;
            verdict_reg <= dnsp_pkg::ST_NONE;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // start over for the next datagram
                pos_reg     <= '0;
                phase_reg   <= dnsp_pkg::PH_HEADER;
                hword_reg   <= '0;
                hbad_reg    <= 1'b0;
                qleft_reg   <= '0;
                aleft_reg   <= '0;
                lbl_reg     <= '0;
                guard_reg   <= '0;
                ptr_reg     <= 1'b0;
                ridx_reg    <= '0;
                rtype_reg   <= '0;
                rdleft_reg  <= '0;
                amatch_reg  <= 1'b0;
                accum_reg   <= '0;
                verdict_reg <= dnsp_pkg::ST_NONE;
            end
            else
            begin
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                hword_reg   <= hword_next;
                hbad_reg    <= hbad_next;
                qleft_reg   <= qleft_next;
                aleft_reg   <= aleft_next;
                lbl_reg     <= lbl_next;
                guard_reg   <= guard_next;
                ptr_reg     <= ptr_next;
                ridx_reg    <= ridx_next;
                rtype_reg   <= rtype_next;
                rdleft_reg  <= rdleft_next;
                amatch_reg  <= amatch_next;
                accum_reg   <= accum_next;
                verdict_reg <= verdict_next;
            end
        end
    end

endmodule

// ===== hdl/dns_response_a_record_parser.sv =====
`timescale 1ns / 1ps
// Top level of the DNS response A-record parser: input register, parser,
// result register and the expected-id register. Depends on dnsp_pkg, dnsp_parser.
//
// Usage:
//   Datagram bytes enter on the s_axis stream, one byte per beat, with
//   s_axis_tlast on the final byte. One verdict beat leaves on m_axis for
//   each datagram, on its last byte: status and, for status 0, the first
//   A-record IPv4 address (first byte in the top bits).
//   cfg_we/cfg_wdata load the expected transaction id; write only while idle.
// Timing:
//   One byte per cycle sustained unless stalled (see Stall). Each byte
//   is first captured in the input register; the parser then loads the
//   verdict into the result register when the last byte is parsed.
// Reset:
//   Clears the parse state, empties both registers and sets the expected
//   id to 0x5A17.
// Stall:
//   While a verdict waits on m_axis, non-last bytes still flow; a further
//   last byte is held in the input register and s_axis_tready drops until
//   the waiting verdict is taken.
module dns_response_a_record_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [1:0] status, [33:2] ipv4_address, zero above
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    dnsp_pkg::result_t out_reg;
    logic [15:0]       txid_reg;
    logic              step;
    dnsp_pkg::result_t result;

    assign s_axis_tready = !in_valid_reg || !in_last_reg || !out_valid_reg;
    assign step = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);

    dnsp_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (in_data_reg),
        .last_byte     (in_last_reg),
        .expected_txid (txid_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            txid_reg <= dnsp_pkg::DEFAULT_TXID;
        else if (cfg_we)
            txid_reg <= cfg_wdata;
    end

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.ipv4_address, out_reg.status};

endmodule
